@@ sv/nulf_pkg.sv @@
`default_nettype none

package nulf_pkg;

    // Default width of the per-level byte totals
    localparam int COUNT_WIDTH = 40;
    // Entries in the command queue between front and back
    localparam int QUEUE_DEPTH = 4;
    // Width of the reported total field
    localparam int TOTAL_W = 40;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    localparam int CFG_DATA_W = 2;
    localparam int OUT_TDATA_W = 56;

    // Header bits that carry the reference priority
    localparam logic [7:0] REF_IDC_MASK = 8'h60;
    // Final byte of a start code
    localparam logic [7:0] START_BYTE = 8'h01;

    typedef enum logic
    {
        REG_FILTER_ENABLE = 1'b0,
        REG_KEEP_LEVEL    = 1'b1
    } cfg_reg_t;

    typedef struct packed
    {
        logic       filter_enable;
        logic [1:0] keep_level;
    } cfg_t;

    // Result words owed for one accepted byte, in emission order:
    // zero bytes, start byte, data byte, then the four level totals.
    typedef struct packed
    {
        logic [2:0] zeros;
        logic       start_one;
        logic       has_byte;
        logic [7:0] data;
        logic       totals;
    } cmd_ctl_t;

endpackage

`default_nettype wire

@@ sv/nal_unit_level_filter_unit.sv @@
// Channel   | Direction | Word contents
// ----------+-----------+-----------------------------------------------------------
// s_axis    | in        | tdata[7:0] stream byte; tlast end of stream
// m_axis    | out       | tdata[7:0] byte, [9:8] level, [49:10] total; tuser kind;
//           |           | tlast final total
// cfg       | in        | cfg_we, cfg_index (0 filter enable, 1 keep level), cfg_data
//
// One byte is accepted per cycle while the command queue has room; the front
// settles each byte in that cycle.
// The back issues one result word per cycle while it has a command and m_axis is ready;
// a byte causes zero to nine words (nine when the header of a kept unit behind a
// four-byte start code ends the stream). Results pass the queue, the back's command
// and output registers; the four-entry queue lets both sides stall on their own.
// Reset is asynchronous and active low; the registers keep their values at end
// of stream, while the front's unit state and level totals return to their reset state.
`default_nettype none

module nal_unit_level_filter_unit #(
    parameter int COUNT_WIDTH = nulf_pkg::COUNT_WIDTH,
    parameter int QUEUE_DEPTH = nulf_pkg::QUEUE_DEPTH
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    input  wire logic [7:0]                          s_axis_tdata,  // stream_byte
    input  wire logic                                s_axis_tlast,
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // out_byte[7:0], level[9:8], level_total[49:10], zero fill
    output logic [nulf_pkg::OUT_TDATA_W-1:0]         m_axis_tdata,
    output logic                                     m_axis_tuser,  // kind
    output logic                                     m_axis_tlast,
    input  wire logic                                cfg_we,
    input  wire logic                                cfg_index,
    input  wire logic [nulf_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int QW = $bits(nulf_pkg::cmd_ctl_t) + 4 * COUNT_WIDTH;

    nulf_pkg::cfg_t              cfg_reg;
    nulf_pkg::cmd_ctl_t          push_ctl;
    nulf_pkg::cmd_ctl_t          head_ctl;
    logic [4*COUNT_WIDTH-1:0]    push_totals;
    logic [4*COUNT_WIDTH-1:0]    head_totals;
    logic [QW-1:0]               head_word;
    logic                        q_push;
    logic                        q_pop;
    logic                        q_full;
    logic                        q_empty;

    // Register writes; an index that names no register changes nothing
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.filter_enable <= 1'b0;
            cfg_reg.keep_level    <= 2'd3;
        end
        else if (cfg_we)
        begin
            case (nulf_pkg::cfg_reg_t'(cfg_index))
                nulf_pkg::REG_FILTER_ENABLE: cfg_reg.filter_enable <= cfg_data[0];
                nulf_pkg::REG_KEEP_LEVEL:    cfg_reg.keep_level    <= cfg_data[1:0];
                default:                     cfg_reg               <= cfg_reg;
            endcase
        end
    end

    // Front: find start codes, track the unit, count bytes per level
    nulf_front #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_byte  (s_axis_tdata),
        .in_eos   (s_axis_tlast),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_ctl    (push_ctl),
        .q_totals (push_totals)
    );

    // Hold commands until the back can expand them
    nulf_queue #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data ({push_totals, push_ctl}),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .head      (head_word)
    );

    assign head_ctl    = head_word[$bits(nulf_pkg::cmd_ctl_t)-1:0];
    assign head_totals = head_word[QW-1:$bits(nulf_pkg::cmd_ctl_t)];

    // Back: expand each command into result words
    nulf_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_pop    (q_pop),
        .q_ctl    (head_ctl),
        .q_totals (head_totals),
        .m_valid  (m_axis_tvalid),
        .m_ready  (m_axis_tready),
        .m_data   (m_axis_tdata),
        .m_user   (m_axis_tuser),
        .m_last   (m_axis_tlast)
    );

`ifndef SYNTHESIS
    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_push && q_full))
        else $error("command pushed into a full queue");

    a_eos_makes_command: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tlast) |-> q_push)
        else $error("end of stream accepted without a totals command");

    a_last_is_total: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> m_axis_tuser)
        else $error("last flag on a forwarded byte");

    a_byte_word_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[55:8] == '0))
        else $error("forwarded byte word carries level or total bits");
`endif

endmodule

`default_nettype wire

@@ sv/nulf_front.sv @@
`default_nettype none

module nulf_front #(
    parameter int COUNT_WIDTH = nulf_pkg::COUNT_WIDTH
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire nulf_pkg::cfg_t             cfg,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic [7:0]                 in_byte,
    input  wire logic                       in_eos,
    input  wire logic                       q_full,
    output logic                            q_push,
    output nulf_pkg::cmd_ctl_t              q_ctl,
    output logic [4*COUNT_WIDTH-1:0]        q_totals
);

    logic                   accept;
    logic [1:0]             zero_run_reg, zero_run_next;
    logic                   inside_reg, inside_next;
    logic                   awaiting_reg, awaiting_next;
    logic                   prefix4_reg, prefix4_next;
    logic [1:0]             unit_level_reg, unit_level_next;
    logic                   unit_kept_reg, unit_kept_next;
    logic [COUNT_WIDTH-1:0] totals_reg [4];
    logic [COUNT_WIDTH-1:0] totals_next [4];

    logic [1:0]             ref_idc;
    logic [1:0]             hdr_level;
    logic                   hdr_kept;
    logic [2:0]             inc;
    logic [1:0]             target;
    logic [COUNT_WIDTH:0]   sum;
    logic [COUNT_WIDTH-1:0] sat;

    assign accept   = in_valid && in_ready;
    assign in_ready = !q_full;

    always_comb
    begin
        zero_run_next   = zero_run_reg;
        inside_next     = inside_reg;
        awaiting_next   = awaiting_reg;
        prefix4_next    = prefix4_reg;
        unit_level_next = unit_level_reg;
        unit_kept_next  = unit_kept_reg;
        q_ctl           = '0;
        inc             = '0;
        target          = unit_level_reg;

        ref_idc   = 2'((in_byte & nulf_pkg::REF_IDC_MASK) >> 5);
        hdr_level = 2'(2'd3 - ref_idc);
        hdr_kept  = cfg.filter_enable && (hdr_level <= cfg.keep_level);

        if (awaiting_reg)
        begin
            // Header byte: fix level and keep decision, credit prefix and header
            unit_level_next = hdr_level;
            unit_kept_next  = hdr_kept;
            target          = hdr_level;
            inc             = prefix4_reg ? 3'd5 : 3'd4;
            awaiting_next   = 1'b0;
            zero_run_next   = '0;
            if (hdr_kept)
            begin
                q_ctl.zeros     = prefix4_reg ? 3'd3 : 3'd2;
                q_ctl.start_one = 1'b1;
                q_ctl.has_byte  = 1'b1;
                q_ctl.data      = in_byte;
            end
        end
        else if (in_byte == 8'h00)
        begin
            if (zero_run_reg == 2'd3)
            begin
                // Release the oldest held zero as payload
                if (inside_reg)
                begin
                    inc = 3'd1;
                end
                if (unit_kept_reg)
                begin
                    q_ctl.zeros = 3'd1;
                end
            end
            else
            begin
                zero_run_next = zero_run_reg + 2'd1;
            end
        end
        else if (in_byte == nulf_pkg::START_BYTE && zero_run_reg[1])
        begin
            prefix4_next   = (zero_run_reg == 2'd3);
            inside_next    = 1'b1;
            awaiting_next  = 1'b1;
            unit_kept_next = 1'b0;
            zero_run_next  = '0;
        end
        else
        begin
            // Held zeros turn out to be payload, then this byte
            if (inside_reg)
            begin
                inc = {1'b0, zero_run_reg} + 3'd1;
            end
            if (unit_kept_reg)
            begin
                q_ctl.zeros    = {1'b0, zero_run_reg};
                q_ctl.has_byte = 1'b1;
                q_ctl.data     = in_byte;
            end
            zero_run_next = '0;
        end

        if (in_eos)
        begin
            // Flush zeros still held, then report the totals
            if (inside_reg)
            begin
                inc = inc + {1'b0, zero_run_next};
            end
            if (unit_kept_reg)
            begin
                q_ctl.zeros = q_ctl.zeros + {1'b0, zero_run_next};
            end
            q_ctl.totals = 1'b1;
        end

        sum = {1'b0, totals_reg[target]} + (COUNT_WIDTH+1)'(inc);
        sat = sum[COUNT_WIDTH] ? {COUNT_WIDTH{1'b1}} : sum[COUNT_WIDTH-1:0];

        for (int i = 0; i < 4; i++)
        begin
            totals_next[i] = (target == 2'(i)) ? sat : totals_reg[i];
            q_totals[i*COUNT_WIDTH +: COUNT_WIDTH] = totals_next[i];
        end

        q_push = accept && (q_ctl.zeros != '0 || q_ctl.start_one || q_ctl.has_byte
                            || q_ctl.totals);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zero_run_reg   <= '0;
            inside_reg     <= 1'b0;
            awaiting_reg   <= 1'b0;
            prefix4_reg    <= 1'b0;
            unit_level_reg <= '0;
            unit_kept_reg  <= 1'b0;
            for (int i = 0; i < 4; i++)
            begin
                totals_reg[i] <= '0;
            end
        end
        else if (accept)
        begin
            if (in_eos)
            begin
                zero_run_reg   <= '0;
                inside_reg     <= 1'b0;
                awaiting_reg   <= 1'b0;
                prefix4_reg    <= 1'b0;
                unit_level_reg <= '0;
                unit_kept_reg  <= 1'b0;
                for (int i = 0; i < 4; i++)
                begin
                    totals_reg[i] <= '0;
                end
            end
            else
            begin
                zero_run_reg   <= zero_run_next;
                inside_reg     <= inside_next;
                awaiting_reg   <= awaiting_next;
                prefix4_reg    <= prefix4_next;
                unit_level_reg <= unit_level_next;
                unit_kept_reg  <= unit_kept_next;
                for (int i = 0; i < 4; i++)
                begin
                    totals_reg[i] <= totals_next[i];
                end
            end
        end
    end

endmodule

`default_nettype wire

@@ sv/nulf_queue.sv @@
`default_nettype none

module nulf_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  full,
    input  wire logic             pop,
    output logic                  empty,
    output logic [WIDTH-1:0]      head
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]    count_reg;

    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = store_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

@@ sv/nulf_back.sv @@
`default_nettype none

module nulf_back #(
    parameter int COUNT_WIDTH = nulf_pkg::COUNT_WIDTH
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             q_empty,
    output logic                                  q_pop,
    input  wire nulf_pkg::cmd_ctl_t               q_ctl,
    input  wire logic [4*COUNT_WIDTH-1:0]         q_totals,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic [nulf_pkg::OUT_TDATA_W-1:0]      m_data,
    output logic                                  m_user,
    output logic                                  m_last
);

    logic                              busy_reg, busy_next;
    nulf_pkg::cmd_ctl_t                cur_reg, cur_next;
    logic [1:0]                        tidx_reg, tidx_next;
    logic [4*COUNT_WIDTH-1:0]          tot_reg;
    logic                              out_valid_reg;
    logic [nulf_pkg::OUT_TDATA_W-1:0]  out_data_reg;
    logic                              out_user_reg;
    logic                              out_last_reg;

    logic                              advance;
    logic                              final_word;
    logic                              sel_kind;
    logic [7:0]                        sel_byte;
    logic [1:0]                        sel_level;
    logic [nulf_pkg::TOTAL_W-1:0]      sel_total;
    logic                              sel_last;
    logic [63:0]                       wide_total;

    assign advance = busy_reg && (!out_valid_reg || m_ready);

    always_comb
    begin
        cur_next   = cur_reg;
        tidx_next  = tidx_reg;
        sel_kind   = 1'b0;
        sel_byte   = '0;
        sel_level  = '0;
        sel_total  = '0;
        sel_last   = 1'b0;
        wide_total = 64'(tot_reg[tidx_reg*COUNT_WIDTH +: COUNT_WIDTH]);

        if (cur_reg.zeros != '0)
        begin
            cur_next.zeros = cur_reg.zeros - 3'd1;
            final_word = (cur_reg.zeros == 3'd1) && !cur_reg.start_one
                         && !cur_reg.has_byte && !cur_reg.totals;
        end
        else if (cur_reg.start_one)
        begin
            sel_byte           = nulf_pkg::START_BYTE;
            cur_next.start_one = 1'b0;
            final_word         = !cur_reg.has_byte && !cur_reg.totals;
        end
        else if (cur_reg.has_byte)
        begin
            sel_byte          = cur_reg.data;
            cur_next.has_byte = 1'b0;
            final_word        = !cur_reg.totals;
        end
        else
        begin
            // Clamp the total to the width of the reported field
            sel_kind  = 1'b1;
            sel_level = tidx_reg;
            sel_total = (wide_total > 64'(nulf_pkg::TOTAL_MAX)) ? nulf_pkg::TOTAL_MAX
                                                                : wide_total[nulf_pkg::TOTAL_W-1:0];
            sel_last  = (tidx_reg == 2'd3);
            tidx_next = tidx_reg + 2'd1;
            final_word = (tidx_reg == 2'd3);
        end

        q_pop = !q_empty && (!busy_reg || (advance && final_word));

        if (q_pop)
        begin
            busy_next = 1'b1;
            cur_next  = q_ctl;
            tidx_next = '0;
        end
        else if (advance && final_word)
        begin
            busy_next = 1'b0;
        end
        else
        begin
            busy_next = busy_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop || advance)
        begin
            cur_reg  <= cur_next;
            tidx_reg <= tidx_next;
        end
        if (q_pop)
        begin
            tot_reg <= q_totals;
        end
        if (advance)
        begin
            out_data_reg <= {6'b0, sel_total, sel_level, sel_byte};
            out_user_reg <= sel_kind;
            out_last_reg <= sel_last;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;
    assign m_user  = out_user_reg;
    assign m_last  = out_last_reg;

endmodule

`default_nettype wire
